// ===== rtl/core/rsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Run-length sprite row decoder package
// Shared types, codes and limits of the sprite row decoder.
// ----------------------------------------------------------------------------
package rsrd_pkg;

  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned PALETTE_ENTRIES = 256;

  localparam logic [10:0] MAX_WIDTH = 11'(MAX_DIM);
  localparam logic [10:0] COL_MAX = 11'd2047;
  localparam logic [7:0] END_MARK = 8'hFF;
  localparam logic [10:0] STARTX_HIGH = 11'd256;

  localparam logic [1:0] CMD_PAL_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DATA = 2'd2;

  localparam logic [1:0] ST_SPAN = 2'd0;
  localparam logic [1:0] ST_FRAME_DONE = 2'd1;
  localparam logic [1:0] ST_ROW_RANGE = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ROW,
    PH_STARTX,
    PH_FLAGS,
    PH_SKIP,
    PH_LEN,
    PH_CODE,
    PH_LIT,
    PH_REP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] pal_addr;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel_row;
    logic [9:0] pixel_x;
    logic [7:0] span_length;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } result_t;

endpackage

// ===== rtl/core/rle_sprite_row_decoder.sv =====
// ----------------------------------------------------------------------------
// Run-length sprite row decoder
// Parses a run-length sprite stream one byte per transfer and emits colored
// spans through a 256-entry RGB palette, plus status results.
// ----------------------------------------------------------------------------
//  Channel  Signals                              Direction
//  item     item_valid, item_ready, item         in
//  result   result_valid, result_ready, result   out
//  config   cfg_write, cfg_index, cfg_data       in
//
// One item is taken per cycle unless the item side is stopped. Toward its
// result, the parser and the palette read fill one register stage, then the
// colors land in the output register. Reset clears the parser and both stage
// valid flags, the palette is not cleared, and no item is taken while reset
// is high. A stalled result holds both stages, and the item side stops only
// when both stages are full.
module rle_sprite_row_decoder (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  rsrd_pkg::item_t         item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output rsrd_pkg::result_t       result,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [10:0]             cfg_data
);

  logic [10:0] frame_width;
  logic [10:0] frame_height;

  rsrd_pkg::phase_t phase, phase_next;
  logic [10:0] rows_seen, rows_seen_next;
  logic [7:0]  current_row, current_row_next;
  logic [10:0] column, column_next;
  logic [7:0]  seg_left, seg_left_next;
  logic [7:0]  run_left, run_left_next;
  logic        last_seg, last_seg_next;

  logic [23:0] palette [rsrd_pkg::PALETTE_ENTRIES];
  logic [23:0] pal_rdata;

  logic        s1_valid;
  logic [1:0]  s1_status;
  logic [7:0]  s1_row;
  logic [9:0]  s1_x;
  logic [7:0]  s1_len;

  logic        accept;
  logic        s1_advance;
  logic        made;
  logic [1:0]  made_status;
  logic [9:0]  made_x;
  logic [7:0]  made_len;

  logic [7:0]  b;
  logic [10:0] eff_width;
  logic [7:0]  seg_dec;
  logic [7:0]  code_run;
  logic [7:0]  need;
  logic [7:0]  span_cnt;
  logic [10:0] room;
  logic [11:0] col_sum;
  logic [10:0] rows_inc;
  logic [7:0]  run_after;

  assign s1_advance = s1_valid && (!result_valid || result_ready);
  assign item_ready = !rst && (!s1_valid || s1_advance);
  assign accept = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd320;
      frame_height <= 11'd200;
    end else if (cfg_write) begin
      if (cfg_index == rsrd_pkg::REG_WIDTH) begin
        frame_width <= cfg_data;
      end else begin
        frame_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == rsrd_pkg::CMD_PAL_WRITE) begin
      palette[item.pal_addr] <= {item.pal_red, item.pal_green, item.pal_blue};
    end
    if (accept && item.command == rsrd_pkg::CMD_DATA) begin
      pal_rdata <= palette[item.data_byte];
    end
  end

  assign b = item.data_byte;
  assign eff_width = (frame_width > rsrd_pkg::MAX_WIDTH) ? rsrd_pkg::MAX_WIDTH : frame_width;
  assign seg_dec = seg_left - 8'd1;
  assign code_run = {1'b0, b[7:1]} + 8'd1;
  assign need = b[0] ? 8'd1 : code_run;
  assign span_cnt = (phase == rsrd_pkg::PH_REP) ? run_left : 8'd1;
  assign room = eff_width - column;
  assign col_sum = {1'b0, column} + {4'd0, span_cnt};
  assign rows_inc = rows_seen + 11'd1;
  assign run_after = (phase == rsrd_pkg::PH_REP) ? 8'd0 : run_left - 8'd1;

  always_comb begin
    phase_next = phase;
    rows_seen_next = rows_seen;
    current_row_next = current_row;
    column_next = column;
    seg_left_next = seg_left;
    run_left_next = run_left;
    last_seg_next = last_seg;
    made = 1'b0;
    made_status = rsrd_pkg::ST_SPAN;
    made_x = 10'd0;
    made_len = 8'd0;
    if (item.command == rsrd_pkg::CMD_START) begin
      phase_next = rsrd_pkg::PH_ROW;
      rows_seen_next = 11'd0;
      current_row_next = 8'd0;
      column_next = 11'd0;
      seg_left_next = 8'd0;
      run_left_next = 8'd0;
      last_seg_next = 1'b0;
    end else if (item.command == rsrd_pkg::CMD_DATA) begin
      unique case (phase) inside
        rsrd_pkg::PH_ROW: begin
          if (b == rsrd_pkg::END_MARK) begin
            phase_next = rsrd_pkg::PH_IDLE;
            made = 1'b1;
            made_status = rsrd_pkg::ST_FRAME_DONE;
          end else if ({3'd0, b} >= frame_height) begin
            phase_next = rsrd_pkg::PH_IDLE;
            made = 1'b1;
            made_status = rsrd_pkg::ST_ROW_RANGE;
          end else begin
            current_row_next = b;
            phase_next = rsrd_pkg::PH_STARTX;
          end
        end
        rsrd_pkg::PH_STARTX: begin
          column_next = {3'd0, b};
          phase_next = rsrd_pkg::PH_FLAGS;
        end
        rsrd_pkg::PH_FLAGS: begin
          if (b[0]) begin
            column_next = column + rsrd_pkg::STARTX_HIGH;
          end
          last_seg_next = b[7];
          phase_next = rsrd_pkg::PH_SKIP;
        end
        rsrd_pkg::PH_SKIP: begin
          phase_next = rsrd_pkg::PH_LEN;
        end
        rsrd_pkg::PH_LEN: begin
          seg_left_next = b;
          if (b == 8'd0) begin
            if (last_seg) begin
              rows_seen_next = rows_inc;
              phase_next = (rows_inc >= frame_height) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_ROW;
            end else begin
              phase_next = rsrd_pkg::PH_STARTX;
            end
          end else begin
            phase_next = rsrd_pkg::PH_CODE;
          end
        end
        rsrd_pkg::PH_CODE: begin
          seg_left_next = seg_dec;
          run_left_next = code_run;
          if (need > seg_dec) begin
            phase_next = rsrd_pkg::PH_IDLE;
            made = 1'b1;
            made_status = rsrd_pkg::ST_OVERRUN;
          end else begin
            phase_next = b[0] ? rsrd_pkg::PH_REP : rsrd_pkg::PH_LIT;
          end
        end
        rsrd_pkg::PH_LIT, rsrd_pkg::PH_REP: begin
          seg_left_next = seg_dec;
          run_left_next = run_after;
          if (column < eff_width) begin
            made = 1'b1;
            made_x = column[9:0];
            made_len = (room > {3'd0, span_cnt}) ? span_cnt : room[7:0];
          end
          column_next = (col_sum > {1'b0, rsrd_pkg::COL_MAX}) ? rsrd_pkg::COL_MAX
                                                             : col_sum[10:0];
          if (run_after == 8'd0) begin
            if (seg_dec == 8'd0) begin
              if (last_seg) begin
                rows_seen_next = rows_inc;
                phase_next = (rows_inc >= frame_height) ? rsrd_pkg::PH_DONE
                                                        : rsrd_pkg::PH_ROW;
              end else begin
                phase_next = rsrd_pkg::PH_STARTX;
              end
            end else begin
              phase_next = rsrd_pkg::PH_CODE;
            end
          end
        end
        rsrd_pkg::PH_DONE: begin
          phase_next = rsrd_pkg::PH_IDLE;
          made = 1'b1;
          made_status = rsrd_pkg::ST_FRAME_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rsrd_pkg::PH_IDLE;
      rows_seen <= 11'd0;
      current_row <= 8'd0;
      column <= 11'd0;
      seg_left <= 8'd0;
      run_left <= 8'd0;
      last_seg <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      rows_seen <= rows_seen_next;
      current_row <= current_row_next;
      column <= column_next;
      seg_left <= seg_left_next;
      run_left <= run_left_next;
      last_seg <= last_seg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= made;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= made_status;
      s1_row <= (made_status == rsrd_pkg::ST_SPAN) ? current_row : 8'd0;
      s1_x <= made_x;
      s1_len <= made_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result.status <= s1_status;
      result.pixel_row <= s1_row;
      result.pixel_x <= s1_x;
      result.span_length <= s1_len;
      if (s1_status == rsrd_pkg::ST_SPAN) begin
        result.out_red <= pal_rdata[23:16];
        result.out_green <= pal_rdata[15:8];
        result.out_blue <= pal_rdata[7:0];
      end else begin
        result.out_red <= 8'd0;
        result.out_green <= 8'd0;
        result.out_blue <= 8'd0;
      end
    end
  end

endmodule

// ===== verif/tb_rle_sprite_row_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite row decoder testbench
// Loads the palette and sends hand-built streams for the special cases. It
// then sends random well-formed frames under changing widths and heights,
// with broken segments and noise mixed in. A local decoder predicts every
// span and status. Each result transfer is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_rle_sprite_row_decoder;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 100;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_ready;
  rsrd_pkg::item_t item;
  logic result_valid;
  logic result_ready;
  rsrd_pkg::result_t result;
  logic cfg_write;
  logic cfg_index;
  logic [10:0] cfg_data;

  // Local copy of the decoder state and settings.
  rsrd_pkg::phase_t dec_phase;
  logic [10:0] rows_done;
  logic [7:0] row_now;
  logic [10:0] column;
  logic [7:0] seg_left;
  logic [7:0] run_left;
  logic last_seg;
  logic [23:0] palette_copy [rsrd_pkg::PALETTE_ENTRIES];
  logic [10:0] cur_width;
  logic [10:0] cur_height;

  rsrd_pkg::result_t expected_spans[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_requests = 0;
  int unsigned cycle_count = 0;

  rle_sprite_row_decoder DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void post_status(input logic [1:0] st);
    rsrd_pkg::result_t r;
    r = '0;
    r.status = st;
    dec_phase = rsrd_pkg::PH_IDLE;
    expected_spans.push_back(r);
  endfunction

  function automatic void close_segment();
    if (last_seg) begin
      rows_done = rows_done + 11'd1;
      dec_phase = (rows_done >= cur_height) ? rsrd_pkg::PH_DONE : rsrd_pkg::PH_ROW;
    end else begin
      dec_phase = rsrd_pkg::PH_STARTX;
    end
  endfunction

  function automatic void close_run();
    if (run_left == 8'd0) begin
      if (seg_left == 8'd0) close_segment();
      else dec_phase = rsrd_pkg::PH_CODE;
    end
  endfunction

  function automatic void paint(input logic [7:0] cnt, input logic [7:0] idx);
    rsrd_pkg::result_t r;
    logic [10:0] lim;
    logic [10:0] room;
    logic [11:0] reach;
    lim = (cur_width < rsrd_pkg::MAX_WIDTH) ? cur_width : rsrd_pkg::MAX_WIDTH;
    if (column < lim) begin
      room = lim - column;
      r.status = rsrd_pkg::ST_SPAN;
      r.pixel_row = row_now;
      r.pixel_x = column[9:0];
      r.span_length = (room > {3'b000, cnt}) ? cnt : room[7:0];
      {r.out_red, r.out_green, r.out_blue} = palette_copy[idx];
      expected_spans.push_back(r);
    end
    reach = {1'b0, column} + {4'b0000, cnt};
    column = (reach > {1'b0, rsrd_pkg::COL_MAX}) ? rsrd_pkg::COL_MAX : reach[10:0];
  endfunction

  function automatic void decode_item(input rsrd_pkg::item_t it);
    logic [7:0] b;
    logic [7:0] need;
    b = it.data_byte;
    case (it.command)
      rsrd_pkg::CMD_PAL_WRITE: begin
        palette_copy[it.pal_addr] = {it.pal_red, it.pal_green, it.pal_blue};
      end
      rsrd_pkg::CMD_START: begin
        dec_phase = rsrd_pkg::PH_ROW;
        rows_done = '0;
        row_now = '0;
        column = '0;
        seg_left = '0;
        run_left = '0;
        last_seg = 1'b0;
      end
      rsrd_pkg::CMD_DATA: begin
        case (dec_phase)
          rsrd_pkg::PH_ROW: begin
            if (b == rsrd_pkg::END_MARK) begin
              post_status(rsrd_pkg::ST_FRAME_DONE);
            end else if ({3'b000, b} >= cur_height) begin
              post_status(rsrd_pkg::ST_ROW_RANGE);
            end else begin
              row_now = b;
              dec_phase = rsrd_pkg::PH_STARTX;
            end
          end
          rsrd_pkg::PH_STARTX: begin
            column = {3'b000, b};
            dec_phase = rsrd_pkg::PH_FLAGS;
          end
          rsrd_pkg::PH_FLAGS: begin
            if (b[0]) column = column + rsrd_pkg::STARTX_HIGH;
            last_seg = b[7];
            dec_phase = rsrd_pkg::PH_SKIP;
          end
          rsrd_pkg::PH_SKIP: dec_phase = rsrd_pkg::PH_LEN;
          rsrd_pkg::PH_LEN: begin
            seg_left = b;
            if (b == 8'd0) close_segment();
            else dec_phase = rsrd_pkg::PH_CODE;
          end
          rsrd_pkg::PH_CODE: begin
            seg_left = seg_left - 8'd1;
            run_left = {1'b0, b[7:1]} + 8'd1;
            need = b[0] ? 8'd1 : run_left;
            if (need > seg_left) post_status(rsrd_pkg::ST_OVERRUN);
            else dec_phase = b[0] ? rsrd_pkg::PH_REP : rsrd_pkg::PH_LIT;
          end
          rsrd_pkg::PH_LIT: begin
            seg_left = seg_left - 8'd1;
            run_left = run_left - 8'd1;
            paint(8'd1, b);
            close_run();
          end
          rsrd_pkg::PH_REP: begin
            seg_left = seg_left - 8'd1;
            paint(run_left, b);
            run_left = '0;
            close_run();
          end
          rsrd_pkg::PH_DONE: post_status(rsrd_pkg::ST_FRAME_DONE);
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : track_transfers
    rsrd_pkg::result_t want;
    if (!rst && item_valid && item_ready) decode_item(item);
    if (!rst && result_valid && result_ready) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("unexpected result status", result.status, 0);
      end else begin
        want = expected_spans.pop_front();
        if (result.status != want.status)
          report_mismatch("status", result.status, want.status);
        if (result.pixel_row != want.pixel_row)
          report_mismatch("pixel_row", result.pixel_row, want.pixel_row);
        if (result.pixel_x != want.pixel_x)
          report_mismatch("pixel_x", result.pixel_x, want.pixel_x);
        if (result.span_length != want.span_length)
          report_mismatch("span_length", result.span_length, want.span_length);
        if (result.out_red != want.out_red)
          report_mismatch("out_red", result.out_red, want.out_red);
        if (result.out_green != want.out_green)
          report_mismatch("out_green", result.out_green, want.out_green);
        if (result.out_blue != want.out_blue)
          report_mismatch("out_blue", result.out_blue, want.out_blue);
      end
    end
  end

  initial begin : result_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned holds_served;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_served = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != stall_requests) begin
        holds_served = stall_requests;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout with %0d results outstanding", expected_spans.size());
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(input rsrd_pkg::item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  task automatic send_command(input logic [1:0] cmd, input logic [7:0] b);
    logic [63:0] raw;
    rsrd_pkg::item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(rsrd_pkg::item_t)-1:0];
    it.command = cmd;
    it.data_byte = b;
    send_item(it);
  endtask

  // Frame bytes, now and then preceded by a palette write.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 24) == 0) send_command(rsrd_pkg::CMD_PAL_WRITE, 8'($urandom));
    send_command(rsrd_pkg::CMD_DATA, b);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [10:0] width, input logic [10:0] height);
    cfg_write <= 1'b1;
    cfg_index <= rsrd_pkg::REG_WIDTH;
    cfg_data <= width;
    @(posedge clk);
    cur_width = width;
    cfg_index <= rsrd_pkg::REG_HEIGHT;
    cfg_data <= height;
    @(posedge clk);
    cur_height = height;
    cfg_write <= 1'b0;
  endtask

  task automatic send_segment(input bit last_one, input int unsigned budget, input bit spoil);
    logic [7:0] codes[$];
    logic [7:0] flags;
    int unsigned n;
    codes = {};
    while (1) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
      if ($urandom_range(0, 1)) begin
        if (codes.size() + 2 > budget) break;
        codes.push_back(8'((n - 1) * 2 + 1));
        codes.push_back(8'($urandom));
      end else begin
        if (codes.size() + n + 1 > budget) break;
        codes.push_back(8'((n - 1) * 2));
        repeat (n) codes.push_back(8'($urandom));
      end
    end
    flags = 8'($urandom);
    flags[7] = last_one;
    send_byte(8'($urandom));
    send_byte(flags);
    send_byte(8'($urandom));
    send_byte(spoil ? 8'($urandom_range(0, codes.size())) : 8'(codes.size()));
    foreach (codes[i]) send_byte(codes[i]);
  endtask

  task automatic send_frame();
    int unsigned rows;
    int unsigned segs;
    int unsigned row_top;
    int unsigned budget;
    rows = $urandom_range(1, (cur_height < 4) ? cur_height : 4);
    if (cur_height <= 4 && $urandom_range(0, 1)) rows = cur_height;
    row_top = (cur_height > 255) ? 254 : cur_height - 1;
    send_command(rsrd_pkg::CMD_START, 8'($urandom));
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(0, 39) == 0) send_command(rsrd_pkg::CMD_START, 8'($urandom));
      if ($urandom_range(0, 24) == 0) send_byte(8'($urandom));
      else send_byte(8'($urandom_range(0, row_top)));
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
        budget = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 14);
        send_segment(s == segs - 1, budget, $urandom_range(0, 29) == 0);
      end
    end
    if (rows >= cur_height) send_byte(8'($urandom));
    else send_byte(rsrd_pkg::END_MARK);
  endtask

  task automatic test_palette_load();
    for (int i = 0; i < rsrd_pkg::PALETTE_ENTRIES; i++) begin
      rsrd_pkg::item_t it;
      it = '0;
      it.command = rsrd_pkg::CMD_PAL_WRITE;
      it.data_byte = 8'($urandom);
      it.pal_addr = 8'(i);
      if (i == 0) begin
        {it.pal_red, it.pal_green, it.pal_blue} = 24'h000000;
      end else if (i == rsrd_pkg::PALETTE_ENTRIES - 1) begin
        {it.pal_red, it.pal_green, it.pal_blue} = 24'hFFFFFF;
      end else begin
        {it.pal_red, it.pal_green, it.pal_blue} = 24'($urandom);
      end
      send_item(it);
    end
  endtask

  // Runs at the reset width and height.
  task automatic test_stream_cases();
    logic [7:0] full_frame[$] = '{8'h00, 8'h00, 8'h00, 8'hAA, 8'h04, 8'hFF, 8'hFF,
                                  8'h00, 8'h00, 8'hFF, 8'h81, 8'h55, 8'h00, 8'hFF};
    logic [7:0] short_seg[$] = '{8'h07, 8'h00, 8'h80, 8'h00, 8'h01, 8'h00, 8'h42};
    send_command(rsrd_pkg::CMD_DATA, 8'h12);
    send_command(CMD_UNUSED, 8'h00);
    send_command(rsrd_pkg::CMD_START, 8'hFF);
    foreach (full_frame[i]) send_command(rsrd_pkg::CMD_DATA, full_frame[i]);
    send_command(rsrd_pkg::CMD_START, 8'h00);
    send_command(rsrd_pkg::CMD_DATA, 8'hC8);
    send_command(rsrd_pkg::CMD_START, 8'h00);
    send_command(rsrd_pkg::CMD_DATA, 8'h05);
    send_command(rsrd_pkg::CMD_DATA, 8'h10);
    send_command(rsrd_pkg::CMD_START, 8'h00);
    foreach (short_seg[i]) send_command(rsrd_pkg::CMD_DATA, short_seg[i]);
  endtask

  task automatic test_frame_completion();
    logic [7:0] one_row[$] = '{8'h00, 8'h14, 8'h00, 8'h00, 8'h02, 8'h01, 8'h10,
                               8'h0F, 8'h80, 8'h00, 8'h02, 8'h03, 8'h80, 8'h37};
    settle();
    apply_settings(11'd16, 11'd1);
    send_command(rsrd_pkg::CMD_START, 8'h00);
    foreach (one_row[i]) send_command(rsrd_pkg::CMD_DATA, one_row[i]);
  endtask

  // The receiver holds off while a long literal run keeps arriving.
  task automatic test_backpressure();
    settle();
    apply_settings(rsrd_pkg::MAX_WIDTH, 11'd1024);
    stall_requests++;
    send_command(rsrd_pkg::CMD_START, 8'h00);
    send_command(rsrd_pkg::CMD_DATA, 8'h03);
    send_command(rsrd_pkg::CMD_DATA, 8'h00);
    send_command(rsrd_pkg::CMD_DATA, 8'h80);
    send_command(rsrd_pkg::CMD_DATA, 8'h00);
    send_command(rsrd_pkg::CMD_DATA, 8'd41);
    send_command(rsrd_pkg::CMD_DATA, 8'd78);
    repeat (40) send_command(rsrd_pkg::CMD_DATA, 8'($urandom));
    send_command(rsrd_pkg::CMD_DATA, rsrd_pkg::END_MARK);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned target;
    int unsigned setting;
    logic [10:0] w;
    logic [10:0] h;
    target = items_sent + RANDOM_ITEMS;
    setting = 0;
    while (items_sent < target) begin
      case (setting % 6)
        0: begin w = 11'd320; h = 11'd200; end
        1: begin w = 11'd1; h = 11'd1; end
        2: begin w = rsrd_pkg::MAX_WIDTH; h = 11'd1024; end
        3: begin w = 11'($urandom_range(1, 64)); h = 11'($urandom_range(1, 4)); end
        4: begin w = 11'($urandom_range(256, 1024)); h = 11'($urandom_range(2, 255)); end
        default: begin
          w = 11'($urandom_range(1, 1024));
          h = 11'($urandom_range(1, 1024));
        end
      endcase
      settle();
      apply_settings(w, h);
      repeat ($urandom_range(2, 5)) begin
        send_frame();
        repeat ($urandom_range(0, 2)) send_command(2'($urandom), 8'($urandom));
      end
      setting++;
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = rsrd_pkg::REG_WIDTH;
    cfg_data = '0;
    dec_phase = rsrd_pkg::PH_IDLE;
    rows_done = '0;
    row_now = '0;
    column = '0;
    seg_left = '0;
    run_left = '0;
    last_seg = 1'b0;
    cur_width = 11'd320;
    cur_height = 11'd200;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_palette_load();
    test_stream_cases();
    test_frame_completion();
    test_backpressure();
    test_random_frames();
    settle();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== rle_sprite_row_decoder.f =====
rtl/core/rsrd_pkg.sv
rtl/core/rle_sprite_row_decoder.sv
verif/tb_rle_sprite_row_decoder.sv
